// File: rtl/mrcsm_pkg.sv
// Shared constants, register codes, controller states and command/status
// structs for the masked row/column sum and mean block. No dependencies.
`default_nettype none

package mrcsm_pkg;

	localparam int MAX_COLS   = 1024;
	localparam int ACC_W      = 48;
	localparam int VAL_W      = 32;
	localparam int LEN_W      = 16;
	localparam int ROW_W      = 16;
	localparam int NCOL_W     = 11;
	localparam int OUT_W      = 48;
	localparam int IDX_W      = 16;
	localparam int EXT_W      = 64;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;
	localparam int COL_W      = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
	localparam int CMP_W      = (COL_W + 1 > NCOL_W) ? COL_W + 1 : NCOL_W;
	localparam int DIV_CNT_W  = $clog2(ACC_W);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_NUM_ROWS     = CFG_IDX_W'(0),
		REG_NUM_COLS     = CFG_IDX_W'(1),
		REG_REDUCE_FRONT = CFG_IDX_W'(2),
		REG_TAKE_MEAN    = CFG_IDX_W'(3),
		REG_USE_LENGTHS  = CFG_IDX_W'(4)
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ACCUM,
		ST_DIV_START,
		ST_DIV_WAIT,
		ST_EMIT
	} ctl_state_t;

	typedef struct packed {
		logic capture;
		logic accum;
		logic div_start;
		logic load_out;
	} dp_cmd_t;

	typedef struct packed {
		logic result_due;
		logic need_div;
		logic div_busy;
		logic div_done;
		logic out_free;
	} dp_sts_t;

	// sign-extend the accumulator and keep the low result bits
	function automatic logic [OUT_W-1:0] to_out(input logic signed [ACC_W-1:0] a);
		logic signed [EXT_W-1:0] w;
		w = EXT_W'(a);
		return w[OUT_W-1:0];
	endfunction

endpackage

`default_nettype wire

// File: rtl/mrcsm_ifs.sv
// Valid/ready channel interfaces for the element input and the result output.
// Depends on mrcsm_pkg for field widths.
`default_nettype none

interface mrcsm_in_if import mrcsm_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic signed [VAL_W-1:0] value;
	logic [LEN_W-1:0]        seg_length;

	modport source(output valid, value, seg_length, input ready);
	modport sink(input valid, value, seg_length, output ready);
endinterface

interface mrcsm_out_if import mrcsm_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic signed [OUT_W-1:0] sum_or_mean;
	logic [IDX_W-1:0]        segment_index;
	logic                    empty_segment;
	logic                    end_of_matrix;

	modport source(output valid, sum_or_mean, segment_index, empty_segment,
		end_of_matrix, input ready);
	modport sink(input valid, sum_or_mean, segment_index, empty_segment,
		end_of_matrix, output ready);
endinterface

`default_nettype wire

// File: rtl/mrcsm_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No package dependencies.
`default_nettype none

module mrcsm_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 1024,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [AW-1:0]            waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [AW-1:0]            raddr,
	output      logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

`default_nettype wire

// File: rtl/mrcsm_div.sv
// Bit-serial restoring divider: signed dividend by unsigned length, quotient
// truncated toward zero, one quotient bit per cycle. Depends on mrcsm_pkg.
`default_nettype none

module mrcsm_div import mrcsm_pkg::*; (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    start,
	input  wire logic signed [ACC_W-1:0] dividend,
	input  wire logic [LEN_W-1:0]        divisor,
	output      logic                    busy,
	output      logic                    done,
	output      logic signed [ACC_W-1:0] quotient
);
	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [LEN_W-1:0]     rem_q;
	logic [ACC_W-1:0]     quo_q;
	logic [LEN_W-1:0]     dvs_q;
	logic                 neg_q;

	logic [LEN_W:0]   rem_sh;
	logic             fits;
	logic [LEN_W:0]   rem_diff;
	logic [LEN_W-1:0] rem_nx;

	assign rem_sh   = {rem_q, quo_q[ACC_W-1]};
	assign fits     = rem_sh >= {1'b0, dvs_q};
	assign rem_diff = rem_sh - {1'b0, dvs_q};
	// remainder stays below the divisor, so it fits the divisor width
	assign rem_nx   = fits ? rem_diff[LEN_W-1:0] : rem_sh[LEN_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + DIV_CNT_W'(1);
				if (cnt_q == DIV_CNT_W'(ACC_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= dividend[ACC_W-1];
			quo_q <= dividend[ACC_W-1] ? (ACC_W'(0) - dividend) : dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= rem_nx;
			quo_q <= {quo_q[ACC_W-2:0], fits};
		end
	end

	assign busy     = busy_q;
	assign done     = done_q;
	assign quotient = neg_q ? $signed(ACC_W'(0) - quo_q) : $signed(quo_q);
endmodule

`default_nettype wire

// File: rtl/mrcsm_ctrl.sv
// Controller state machine: sequences capture, accumulate, divide and emit
// for one element at a time. Depends on mrcsm_pkg.
`default_nettype none

module mrcsm_ctrl import mrcsm_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    in_valid,
	output      logic    in_ready,
	input  wire dp_sts_t sts,
	output      dp_cmd_t cmd
);
	ctl_state_t state_q;
	ctl_state_t state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_nx = ST_ACCUM;
				end
			end
			ST_ACCUM: begin
				if (!sts.result_due) begin
					state_nx = ST_IDLE;
				end else if (sts.need_div) begin
					state_nx = ST_DIV_START;
				end else begin
					state_nx = ST_EMIT;
				end
			end
			ST_DIV_START: begin
				state_nx = ST_DIV_WAIT;
			end
			ST_DIV_WAIT: begin
				if (sts.div_done) begin
					state_nx = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (sts.out_free) begin
					state_nx = ST_IDLE;
				end
			end
			default: begin
				state_nx = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		in_ready      = 1'b0;
		cmd           = '0;
		case (state_q)
			ST_IDLE: begin
				in_ready    = 1'b1;
				cmd.capture = in_valid;
			end
			ST_ACCUM: begin
				cmd.accum = 1'b1;
			end
			ST_DIV_START: begin
				cmd.div_start = 1'b1;
			end
			ST_DIV_WAIT: begin
				cmd = '0;
			end
			ST_EMIT: begin
				cmd.load_out = sts.out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end
endmodule

`default_nettype wire

// File: rtl/mrcsm_dp.sv
// Datapath: configuration registers, positions, row accumulator, column
// store, divider and output register. Depends on mrcsm_pkg, mrcsm_ram,
// mrcsm_div and mrcsm_out_if.
`default_nettype none

module mrcsm_dp import mrcsm_pkg::*; (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    cfg_wr_en,
	input  wire logic [CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [CFG_DATA_W-1:0]   cfg_data,
	input  wire logic signed [VAL_W-1:0] elem_value,
	input  wire logic [LEN_W-1:0]        elem_seg_length,
	input  wire dp_cmd_t                 cmd,
	output      dp_sts_t                 sts,
	mrcsm_out_if.source                  result
);
	logic [ROW_W-1:0]  num_rows_q;
	logic [NCOL_W-1:0] num_cols_q;
	logic              reduce_front_q;
	logic              take_mean_q;
	logic              use_lengths_q;

	logic [ROW_W-1:0]        row_q;
	logic [COL_W-1:0]        col_q;
	logic signed [ACC_W-1:0] row_sum_q;

	logic signed [VAL_W-1:0] val_s1;
	logic [LEN_W-1:0]        len_s1;

	logic signed [ACC_W-1:0] res_sum_q;
	logic [LEN_W-1:0]        res_len_q;
	logic [IDX_W-1:0]        res_idx_q;
	logic                    res_empty_q;
	logic                    res_eom_q;
	logic                    res_mean_q;

	logic                    out_valid_q;
	logic signed [OUT_W-1:0] out_val_q;
	logic [IDX_W-1:0]        out_idx_q;
	logic                    out_empty_q;
	logic                    out_eom_q;

	logic [ROW_W-1:0]        rows_eff;
	logic [CMP_W-1:0]        ncol_x;
	logic [CMP_W-1:0]        cols_eff;
	logic [CMP_W-1:0]        col_x;
	logic                    last_row;
	logic                    last_col;
	logic [LEN_W-1:0]        len_lim;
	logic [LEN_W-1:0]        len_eff;
	logic [LEN_W-1:0]        pos;
	logic                    take;
	logic                    first;
	logic [ACC_W-1:0]        ram_rd;
	logic signed [ACC_W-1:0] base;
	logic signed [ACC_W-1:0] addend;
	logic signed [ACC_W-1:0] acc_sum;
	logic                    empty;
	logic                    div_busy;
	logic                    div_done;
	logic signed [ACC_W-1:0] quotient;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_rows_q     <= ROW_W'(1);
			num_cols_q     <= NCOL_W'(1);
			reduce_front_q <= 1'b0;
			take_mean_q    <= 1'b0;
			use_lengths_q  <= 1'b0;
		end else if (cfg_wr_en) begin
			case (cfg_reg_t'(cfg_index))
				REG_NUM_ROWS:     num_rows_q     <= cfg_data[ROW_W-1:0];
				REG_NUM_COLS:     num_cols_q     <= cfg_data[NCOL_W-1:0];
				REG_REDUCE_FRONT: reduce_front_q <= cfg_data[0];
				REG_TAKE_MEAN:    take_mean_q    <= cfg_data[0];
				REG_USE_LENGTHS:  use_lengths_q  <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	// zero dimensions act as one, columns clamp to the store depth
	assign rows_eff = (num_rows_q == '0) ? ROW_W'(1) : num_rows_q;
	assign ncol_x   = CMP_W'(num_cols_q);
	always_comb begin
		if (ncol_x == '0) begin
			cols_eff = CMP_W'(1);
		end else if (ncol_x > CMP_W'(MAX_COLS)) begin
			cols_eff = CMP_W'(MAX_COLS);
		end else begin
			cols_eff = ncol_x;
		end
	end

	// a position past the dimension counts as the last one
	assign col_x    = CMP_W'(col_q);
	assign last_col = col_x >= (cols_eff - CMP_W'(1));
	assign last_row = row_q >= (rows_eff - ROW_W'(1));

	assign len_lim = reduce_front_q ? LEN_W'(rows_eff) : LEN_W'(cols_eff);
	assign len_eff = (!use_lengths_q || (len_s1 > len_lim)) ? len_lim : len_s1;
	assign pos     = reduce_front_q ? LEN_W'(row_q) : LEN_W'(col_q);
	assign take    = pos < len_eff;
	assign first   = reduce_front_q ? (row_q == '0) : (col_q == '0);
	assign empty   = len_eff == '0;

	assign base    = first ? '0 : (reduce_front_q ? $signed(ram_rd) : row_sum_q);
	assign addend  = take ? ACC_W'(val_s1) : '0;
	assign acc_sum = base + addend;

	mrcsm_ram #(
		.WIDTH(ACC_W),
		.DEPTH(MAX_COLS)
	) u_col_store (
		.clk  (clk),
		.we   (cmd.accum & reduce_front_q),
		.waddr(col_q),
		.wdata(acc_sum),
		.re   (cmd.capture),
		.raddr(col_q),
		.rdata(ram_rd)
	);

	mrcsm_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cmd.div_start),
		.dividend(res_sum_q),
		.divisor (res_len_q),
		.busy    (div_busy),
		.done    (div_done),
		.quotient(quotient)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q     <= '0;
			col_q     <= '0;
			row_sum_q <= '0;
		end else if (cmd.accum) begin
			if (!reduce_front_q) begin
				row_sum_q <= acc_sum;
			end
			if (last_col) begin
				col_q <= '0;
				row_q <= last_row ? '0 : (row_q + ROW_W'(1));
			end else begin
				col_q <= col_q + COL_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			val_s1 <= elem_value;
			len_s1 <= elem_seg_length;
		end
		if (cmd.accum) begin
			res_sum_q   <= acc_sum;
			res_len_q   <= len_eff;
			res_idx_q   <= reduce_front_q ? IDX_W'(col_q) : IDX_W'(row_q);
			res_empty_q <= empty;
			res_eom_q   <= reduce_front_q ? last_col : last_row;
			res_mean_q  <= take_mean_q & ~empty;
		end
	end

	// output word register: frees the controller while a result waits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_val_q   <= res_empty_q ? '0 :
				$signed(to_out(res_mean_q ? quotient : res_sum_q));
			out_idx_q   <= res_idx_q;
			out_empty_q <= res_empty_q;
			out_eom_q   <= res_eom_q;
		end
	end

	assign result.valid         = out_valid_q;
	assign result.sum_or_mean   = out_val_q;
	assign result.segment_index = out_idx_q;
	assign result.empty_segment = out_empty_q;
	assign result.end_of_matrix = out_eom_q;

	always_comb begin
		sts.result_due = reduce_front_q ? last_row : last_col;
		sts.need_div   = take_mean_q & ~empty;
		sts.div_busy   = div_busy;
		sts.div_done   = div_done;
		sts.out_free   = ~out_valid_q | result.ready;
	end
endmodule

`default_nettype wire

// File: rtl/masked_row_column_sum_mean.sv
// Masked row/column segmented sum and mean over a streamed matrix.
// Top level: joins controller and datapath. Depends on mrcsm_pkg, mrcsm_ifs,
// mrcsm_ctrl and mrcsm_dp.
//
// Usage:
//  - elem carries one matrix element per word (value, seg_length), row-major.
//    result carries one word per finished row (back mode) or per column
//    during the last row (front mode).
//  - Registers are written over cfg_wr_en/cfg_index/cfg_data while idle.
//  - Elements are handled one at a time: an element that ends no segment
//    passes IDLE and ACCUM; one that ends a segment also passes EMIT, and
//    in mean mode, for a non-empty segment, DIV_START and DIV_WAIT before
//    it, while the bit-serial divider makes one quotient bit per cycle over
//    the 48-bit accumulator.
//  - A result word is loaded in EMIT and sits in an output register; the
//    block keeps taking elements while it waits and stalls only when a
//    second result is ready before the first is taken.
//  - Reset clears registers to one row, one column, back sum mode, and
//    clears positions and the row sum. The column store needs no clearing:
//    the first row of each matrix writes every entry before it is read.
`default_nettype none

module masked_row_column_sum_mean import mrcsm_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	mrcsm_in_if.sink                   elem,
	mrcsm_out_if.source                result,
	input  wire logic                  cfg_wr_en,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);
	dp_cmd_t cmd;
	dp_sts_t sts;
	logic    in_ready;

	mrcsm_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(elem.valid),
		.in_ready(in_ready),
		.sts     (sts),
		.cmd     (cmd)
	);

	mrcsm_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.elem_value     (elem.value),
		.elem_seg_length(elem.seg_length),
		.cmd            (cmd),
		.sts            (sts),
		.result         (result)
	);

	assign elem.ready = in_ready;

	// one element in flight: no accept right after an accept
	a_no_back_to_back: assert property (@(posedge clk) disable iff (!arst_n)
		(elem.valid && elem.ready) |=> !elem.ready)
		else $error("element accepted while previous one still in work");

	// never overwrite a result word that has not been taken
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> sts.out_free)
		else $error("output register loaded while full");

	// divider restarts only when idle
	a_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |-> !sts.div_busy)
		else $error("divider started while busy");

	// an empty segment always reports zero
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.empty_segment) |-> (result.sum_or_mean == '0))
		else $error("empty segment with nonzero result");
endmodule

`default_nettype wire
